// ===== rtl/wdm2_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the rank-2 Wigner D block.
`timescale 1ns / 1ps
`default_nettype none
package wdm2_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_MAX        = 24;

    localparam int IN_W   = 64;
    localparam int OUT_W  = 40;
    localparam int ANG_W  = 21;      // widest phase k*alpha + m*gamma, Q.6 degrees
    localparam int Z_W    = 25;      // CORDIC angle, Q.16 degrees
    localparam int XY_W   = 34;      // CORDIC x/y and d, Q30
    localparam int RES_W  = 18;

    localparam logic signed [XY_W-1:0] GAIN_Q30   = 34'sd652032874;
    localparam logic signed [XY_W-1:0] ONE_Q30    = 34'sd1073741824;
    localparam logic signed [31:0]     SQRT3_8_Q30 = 32'sd657529896;
    localparam logic signed [31:0]     SQRT3_2_Q30 = 32'sd1315059792;

    localparam logic [RES_W-1:0] RES_ONE = 18'd65536;

    typedef struct packed {
        logic       valid;
        logic       special;   // result forced to 1+0i
        logic       outside;   // rank or index outside computed set
        logic [4:0] code;      // (k+2)*5 + (m+2)
    } ctl_t;

    // arctangent of 2^-i in Q.16 degrees, rounded to nearest
    function automatic logic [21:0] atan_q16(input int i);
        logic [21:0] v;
        case (i)
            0:  v = 22'd2949120;
            1:  v = 22'd1740967;
            2:  v = 22'd919879;
            3:  v = 22'd466945;
            4:  v = 22'd234379;
            5:  v = 22'd117304;
            6:  v = 22'd58666;
            7:  v = 22'd29335;
            8:  v = 22'd14668;
            9:  v = 22'd7334;
            10: v = 22'd3667;
            11: v = 22'd1833;
            12: v = 22'd917;
            13: v = 22'd458;
            14: v = 22'd229;
            15: v = 22'd115;
            16: v = 22'd57;
            17: v = 22'd29;
            18: v = 22'd14;
            19: v = 22'd7;
            20: v = 22'd4;
            21: v = 22'd2;
            22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/wigner_d_matrix_rank2_top.sv =====
// Top level of the rank-2 Wigner D matrix element pipeline.
// Each input item (rank l, indices k and m, Euler angles alpha, beta, gamma in
// signed Q10.6 degrees) yields one result item D = d(beta)*exp(-i(k*alpha+m*gamma))
// as signed Q2.16 real and imaginary parts, rounded and saturated. Rank 0 with
// k = m = 0 gives 1+0i; any other rank, or |k| or |m| above the rank, gives 1+0i
// with m_tuser set. The block is fully pipelined and takes one item per clock
// while s_tready is high. The input stage loads at the accepting edge, followed
// by four stages of angle reduction, one per CORDIC iteration, two for d, one
// for the final complex products and the output register. Cosine and sine
// of beta and of the phase come from two unrolled CORDIC pipelines running side
// by side. The whole pipeline advances together; a two-entry output stage
// (output register plus skid register) lets the input keep flowing while a
// result waits, and s_tready drops only when both entries are full.
`timescale 1ns / 1ps
`default_nettype none
module wigner_d_matrix_rank2_top
#(
    parameter int CORDIC_STAGES = wdm2_pkg::CORDIC_STAGES_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // rank[3:0], index_k[7:4], index_m[11:8], angle_alpha[27:12],
    // angle_beta[43:28], angle_gamma[59:44], zero pad
    input  wire logic [wdm2_pkg::IN_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // value_real[17:0], value_imag[35:18], zero pad
    output logic [wdm2_pkg::OUT_W-1:0]      m_tdata,
    // out_of_domain[0]
    output logic                            m_tuser
);
    import wdm2_pkg::*;

    localparam int NS      = (CORDIC_STAGES < CORDIC_MAX) ? CORDIC_STAGES : CORDIC_MAX;
    localparam int CTL_LEN = 5 + NS;   // input stage + reduction + CORDIC

    typedef struct packed {
        logic [RES_W-1:0] re;
        logic [RES_W-1:0] im;
        logic             ood;
    } res_t;

    logic ce;

    // ---------------- input stage ----------------
    logic [3:0]         l_in;
    logic signed [3:0]  k_in, m_in;
    logic signed [15:0] a_in, b_in, g_in;
    logic [3:0]         ak, am;
    logic               outside;
    logic signed [19:0] pka, pmg;
    logic signed [7:0]  code_w;
    ctl_t               ctl_in;

    logic signed [ANG_W-1:0] phase_reg, beta_reg;
    ctl_t ctl_reg [0:CTL_LEN-1];

    always_comb
    begin
        l_in = s_tdata[3:0];
        k_in = s_tdata[7:4];
        m_in = s_tdata[11:8];
        a_in = s_tdata[27:12];
        b_in = s_tdata[43:28];
        g_in = s_tdata[59:44];
        ak = k_in[3] ? 4'(-k_in) : 4'(k_in);
        am = m_in[3] ? 4'(-m_in) : 4'(m_in);
        outside = (l_in != 4'd0 && l_in != 4'd2) || ak > l_in || am > l_in;
        pka = k_in * a_in;
        pmg = m_in * g_in;
        code_w = (8'(k_in) + 8'sd2) * 8'sd5 + (8'(m_in) + 8'sd2);
        ctl_in.valid   = s_tvalid;
        ctl_in.special = outside || (l_in == 4'd0);
        ctl_in.outside = outside;
        ctl_in.code    = code_w[4:0];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            phase_reg <= ANG_W'(pka) + ANG_W'(pmg);
            beta_reg  <= ANG_W'(b_in);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CTL_LEN; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (ce)
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < CTL_LEN; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // ---------------- reduction and CORDIC ----------------
    logic signed [Z_W-1:0]  zb, zp;
    logic                   nb, np;
    logic signed [XY_W-1:0] cb, sb, cp, sp;

    wdm2_reduce u_red_beta  (.clk(clk), .ce(ce), .ang(beta_reg),  .z(zb), .neg(nb));
    wdm2_reduce u_red_phase (.clk(clk), .ce(ce), .ang(phase_reg), .z(zp), .neg(np));

    wdm2_cordic #(.STAGES(NS)) u_cordic_beta
    (
        .clk(clk), .ce(ce), .z_in(zb), .neg_in(nb), .cos_out(cb), .sin_out(sb)
    );
    wdm2_cordic #(.STAGES(NS)) u_cordic_phase
    (
        .clk(clk), .ce(ce), .z_in(zp), .neg_in(np), .cos_out(cp), .sin_out(sp)
    );

    // ---------------- d(beta), phase aligned alongside ----------------
    logic signed [XY_W-1:0] d;
    logic signed [XY_W-1:0] cp1_reg, sp1_reg, cp2_reg, sp2_reg;
    ctl_t ctl_d1_reg, ctl_d2_reg, ctl_f_reg;

    wdm2_dcalc u_dcalc
    (
        .clk(clk), .ce(ce), .code(ctl_reg[CTL_LEN-1].code), .cb(cb), .sb(sb), .d(d)
    );

    // ---------------- complex products ----------------
    logic signed [2*XY_W-1:0] pr_reg, pi_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            cp1_reg <= cp;
            sp1_reg <= sp;
            cp2_reg <= cp1_reg;
            sp2_reg <= sp1_reg;
            pr_reg  <= d * cp2_reg;
            pi_reg  <= -(d * sp2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_d1_reg <= '0;
            ctl_d2_reg <= '0;
            ctl_f_reg  <= '0;
        end
        else if (ce)
        begin
            ctl_d1_reg <= ctl_reg[CTL_LEN-1];
            ctl_d2_reg <= ctl_d1_reg;
            ctl_f_reg  <= ctl_d2_reg;
        end
    end

    // round half up to Q16, saturate
    function automatic logic [RES_W-1:0] to_res(input logic signed [2*XY_W-1:0] p);
        logic signed [2*XY_W-1:0] v;
        v = (p + ((2*XY_W)'(1) <<< 43)) >>> 44;
        if (v > 131071)
            return 18'h1FFFF;
        else if (v < -131072)
            return 18'h20000;
        else
            return v[RES_W-1:0];
    endfunction

    res_t item;
    always_comb
    begin
        if (ctl_f_reg.special)
        begin
            item.re  = RES_ONE;
            item.im  = '0;
            item.ood = ctl_f_reg.outside;
        end
        else
        begin
            item.re  = to_res(pr_reg);
            item.im  = to_res(pi_reg);
            item.ood = 1'b0;
        end
    end

    // ---------------- output register with skid ----------------
    res_t out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg;
    logic out_free;

    assign ce       = !skid_valid_reg;
    assign s_tready = ce;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            if (out_free)
            begin
                out_valid_reg <= ctl_f_reg.valid;
            end
            else if (ctl_f_reg.valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_free)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            if (out_free)
            begin
                out_reg <= item;
            end
            else
            begin
                skid_reg <= item;
            end
        end
        else if (out_free)
        begin
            out_reg <= skid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W - 2*RES_W)'(0), out_reg.im, out_reg.re};
    assign m_tuser  = out_reg.ood;
endmodule
`default_nettype wire

// ===== rtl/wdm2_reduce.sv =====
// Four-stage reduction of a Q.6 degree angle to +-90 degrees plus a negate flag.
`timescale 1ns / 1ps
`default_nettype none
module wdm2_reduce
(
    input  wire logic                            clk,
    input  wire logic                            ce,
    input  wire logic signed [wdm2_pkg::ANG_W-1:0] ang,
    output logic signed [wdm2_pkg::Z_W-1:0]        z,
    output logic                                 neg
);
    import wdm2_pkg::*;

    localparam int FULL    = 23040;
    localparam int HALF    = 11520;
    localparam int QUARTER = 5760;
    localparam int OFFSET  = 24 * FULL;   // makes every angle non-negative
    localparam int RECIP   = 46603;       // floor(2^30 / FULL)

    logic [ANG_W-1:0] u1_reg, u2_reg;
    logic [5:0]       q2_reg;
    logic [14:0]      r3_reg;
    logic signed [Z_W-1:0] z4_reg;
    logic             n4_reg;

    logic [ANG_W+15:0] qprod;
    logic [16:0]       r0;
    logic signed [15:0] rs;
    logic signed [15:0] rf;
    logic              nf;

    always_comb
    begin
        qprod = u1_reg * 16'(RECIP);
        // quotient may fall short by one; one corrective subtract
        r0 = 17'(u2_reg) - 17'(q2_reg * 15'(FULL));
        rs = (r3_reg >= 15'(HALF)) ? 16'($signed({1'b0, r3_reg}) - 16'sd23040)
                                   : $signed({1'b0, r3_reg});
        rf = rs;
        nf = 1'b0;
        if (rs > 16'(QUARTER))
        begin
            rf = rs - 16'(HALF);
            nf = 1'b1;
        end
        else if (rs < -16'(QUARTER))
        begin
            rf = rs + 16'(HALF);
            nf = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            u1_reg <= ANG_W'(ang + ANG_W'(OFFSET));
            u2_reg <= u1_reg;
            q2_reg <= qprod[35:30];
            r3_reg <= (r0 >= 17'(FULL)) ? 15'(r0 - 17'(FULL)) : r0[14:0];
            z4_reg <= Z_W'(rf) <<< 10;
            n4_reg <= nf;
        end
    end

    assign z   = z4_reg;
    assign neg = n4_reg;
endmodule
`default_nettype wire

// ===== rtl/wdm2_cordic.sv =====
// Unrolled rotation-mode CORDIC, one register stage per iteration.
`timescale 1ns / 1ps
`default_nettype none
module wdm2_cordic
#(
    parameter int STAGES = wdm2_pkg::CORDIC_STAGES_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             ce,
    input  wire logic signed [wdm2_pkg::Z_W-1:0]  z_in,
    input  wire logic                             neg_in,
    output logic signed [wdm2_pkg::XY_W-1:0]      cos_out,
    output logic signed [wdm2_pkg::XY_W-1:0]      sin_out
);
    import wdm2_pkg::*;

    logic signed [XY_W-1:0] x_reg [0:STAGES-1];
    logic signed [XY_W-1:0] y_reg [0:STAGES-1];
    logic signed [Z_W-1:0]  z_reg [0:STAGES-1];
    logic                   n_reg [0:STAGES-1];

    genvar i;
    generate
        for (i = 0; i < STAGES; i++)
        begin : g_stage
            logic signed [XY_W-1:0] xi, yi;
            logic signed [Z_W-1:0]  zi;
            logic                   ni;
            logic signed [Z_W-1:0]  at;
            if (i == 0)
            begin : g_first
                assign xi = GAIN_Q30;
                assign yi = '0;
                assign zi = z_in;
                assign ni = neg_in;
            end
            else
            begin : g_rest
                assign xi = x_reg[i-1];
                assign yi = y_reg[i-1];
                assign zi = z_reg[i-1];
                assign ni = n_reg[i-1];
            end
            assign at = Z_W'(atan_q16(i));
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    if (zi >= 0)
                    begin
                        x_reg[i] <= xi - (yi >>> i);
                        y_reg[i] <= yi + (xi >>> i);
                        z_reg[i] <= zi - at;
                    end
                    else
                    begin
                        x_reg[i] <= xi + (yi >>> i);
                        y_reg[i] <= yi - (xi >>> i);
                        z_reg[i] <= zi + at;
                    end
                    n_reg[i] <= ni;
                end
            end
        end
    endgenerate

    assign cos_out = n_reg[STAGES-1] ? -x_reg[STAGES-1] : x_reg[STAGES-1];
    assign sin_out = n_reg[STAGES-1] ? -y_reg[STAGES-1] : y_reg[STAGES-1];
endmodule
`default_nettype wire

// ===== rtl/wdm2_dcalc.sv =====
// Two-stage reduced rank-2 d(beta) from cos and sin of beta.
`timescale 1ns / 1ps
`default_nettype none
module wdm2_dcalc
(
    input  wire logic                            clk,
    input  wire logic                            ce,
    input  wire logic [4:0]                      code,
    input  wire logic signed [wdm2_pkg::XY_W-1:0] cb,
    input  wire logic signed [wdm2_pkg::XY_W-1:0] sb,
    output logic signed [wdm2_pkg::XY_W-1:0]      d
);
    import wdm2_pkg::*;

    typedef enum logic [2:0] {
        MODE_PASS  = 3'b001,
        MODE_CONST = 3'b010,
        MODE_THREE = 3'b100
    } mode_t;

    logic signed [XY_W:0] a, b;
    logic [5:0]           sh;
    mode_t                mode;
    logic                 cneg, csel;
    logic signed [2*XY_W+1:0] p1;
    logic signed [2*XY_W+1:0] p1r;

    logic signed [35:0]   p1_reg;
    mode_t                mode_reg;
    logic                 cneg_reg, csel_reg;
    logic signed [XY_W-1:0] d_reg;

    logic signed [32:0]   pm;
    logic signed [64:0]   p2;
    logic signed [37:0]   t3;
    logic signed [XY_W-1:0] d_next;

    always_comb
    begin
        logic signed [XY_W:0] c1, s1, one;
        c1  = (XY_W+1)'(cb);
        s1  = (XY_W+1)'(sb);
        one = (XY_W+1)'(ONE_Q30);
        a = s1; b = s1; sh = 6'd30; mode = MODE_PASS; cneg = 1'b0; csel = 1'b0;
        case (code)
            5'd24, 5'd0:  begin a = one + c1;  b = one + c1;  sh = 6'd32; end
            5'd23, 5'd5:  begin a = -s1;       b = one + c1;  sh = 6'd31; end
            5'd19, 5'd1:  begin a = s1;        b = one + c1;  sh = 6'd31; end
            5'd2, 5'd10, 5'd22, 5'd14:
                          begin a = s1; b = s1; sh = 6'd30; mode = MODE_CONST; end
            5'd21, 5'd15: begin a = s1;        b = c1 - one;  sh = 6'd31; end
            5'd3, 5'd9:   begin a = -s1;       b = c1 - one;  sh = 6'd31; end
            5'd20, 5'd4:  begin a = one - c1;  b = one - c1;  sh = 6'd32; end
            5'd18, 5'd6:  begin a = 2*c1 - one; b = one + c1; sh = 6'd31; end
            5'd16, 5'd8:  begin a = 2*c1 + one; b = one - c1; sh = 6'd31; end
            5'd17, 5'd11: begin a = s1; b = c1; mode = MODE_CONST; cneg = 1'b1; csel = 1'b1; end
            5'd13, 5'd7:  begin a = s1; b = c1; mode = MODE_CONST; csel = 1'b1; end
            5'd12:        begin a = c1; b = c1; mode = MODE_THREE; end
            default:      begin a = '0; b = '0; end
        endcase
        p1  = a * b;
        p1r = (p1 + ((2*XY_W+2)'(1) <<< (sh - 6'd1))) >>> sh;
    end

    always_comb
    begin
        // sin*cos can be negative: keep the sign when narrowing
        pm = cneg_reg ? -33'(p1_reg) : 33'(p1_reg);
        p2 = pm * (csel_reg ? SQRT3_2_Q30 : SQRT3_8_Q30);
        t3 = 38'(p1_reg) * 38'sd3 - 38'(ONE_Q30) + 38'sd1;
        case (mode_reg)
            MODE_CONST: d_next = XY_W'((p2 + (65'sd1 <<< 29)) >>> 30);
            MODE_THREE: d_next = XY_W'(t3 >>> 1);
            default:    d_next = XY_W'(p1_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p1_reg   <= 36'(p1r);
            mode_reg <= mode;
            cneg_reg <= cneg;
            csel_reg <= csel;
            d_reg    <= d_next;
        end
    end

    assign d = d_reg;
endmodule
`default_nettype wire

// ===== tb/wigner_d_matrix_rank2_top_tb.sv =====
// Self-checking testbench for the rank-2 Wigner D matrix element pipeline.
`timescale 1ns / 1ps
module wigner_d_matrix_rank2_top_tb;
    import wdm2_pkg::*;

    // Stage count used by the instance and by the predictor.
    localparam int STAGES = CORDIC_STAGES_DEF;
    // Cycles in which no item is accepted and no result is taken before the run is ended.
    localparam int STALL_LIMIT = 20000;

    // One expected result item.
    typedef struct packed {
        logic signed [17:0] re;
        logic signed [17:0] im;
        logic               ood;
    } elem_t;

    // Floor shift of a signed value.
    function automatic longint sfloor(longint v, int s);
        return v >>> s;
    endfunction

    // Product rounded half up, then shifted.
    function automatic longint rmul(longint a, longint b, int sh);
        return sfloor(a * b + (longint'(1) << (sh - 1)), sh);
    endfunction

    // CORDIC cos and sin, Q30, of an angle in Q.6 degrees.
    task automatic trig(input longint ang, output longint c, output longint s);
        longint r, x, y, z, dx, dy;
        bit neg;
        neg = 0;
        r = ang % 23040;
        if (r < 0) r += 23040;
        if (r >= 11520) r -= 23040;
        if (r > 5760) begin r -= 11520; neg = 1; end
        else if (r < -5760) begin r += 11520; neg = 1; end
        x = GAIN_Q30;
        y = 0;
        z = r * 1024;
        for (int i = 0; i < STAGES && i < CORDIC_MAX; i++)
        begin
            dx = sfloor(y, i);
            dy = sfloor(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(atan_q16(i));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(atan_q16(i));
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    function automatic logic [17:0] sat16(longint p);
        longint v;
        v = sfloor(p + (longint'(1) << 43), 44);
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        return v[17:0];
    endfunction

    // Expected matrix element for one packed input item.
    task automatic wigner_elem(input logic [IN_W-1:0] w, output elem_t e);
        longint l, k, m, a, b, g, cb, sb, cp, sp, d, one;
        bit outside;
        l = w[3:0];
        k = $signed(w[7:4]);
        m = $signed(w[11:8]);
        a = $signed(w[27:12]);
        b = $signed(w[43:28]);
        g = $signed(w[59:44]);
        one = ONE_Q30;
        outside = (l != 0 && l != 2) || (k < 0 ? -k : k) > l || (m < 0 ? -m : m) > l;
        if (outside || l == 0)
        begin
            e.re = RES_ONE; e.im = 0; e.ood = outside;
            return;
        end
        trig(b, cb, sb);
        case ((k + 2) * 5 + (m + 2))
            24, 0:  d = rmul(one + cb, one + cb, 32);
            23, 5:  d = rmul(-sb, one + cb, 31);
            19, 1:  d = rmul(sb, one + cb, 31);
            2, 10, 22, 14: d = rmul(SQRT3_8_Q30, rmul(sb, sb, 30), 30);
            21, 15: d = rmul(sb, cb - one, 31);
            3, 9:   d = rmul(-sb, cb - one, 31);
            20, 4:  d = rmul(one - cb, one - cb, 32);
            18, 6:  d = rmul(2 * cb - one, one + cb, 31);
            16, 8:  d = rmul(2 * cb + one, one - cb, 31);
            17, 11: d = rmul(-rmul(sb, cb, 30), SQRT3_2_Q30, 30);
            13, 7:  d = rmul(rmul(sb, cb, 30), SQRT3_2_Q30, 30);
            12:     d = sfloor(3 * rmul(cb, cb, 30) - one + 1, 1);
            default: d = 0;
        endcase
        trig(k * a + m * g, cp, sp);
        e.re = sat16(d * cp);
        e.im = sat16(-(d * sp));
        e.ood = 0;
    endtask

    // Holds predicted elements in order and compares arriving results.
    class elem_scoreboard;
        elem_t pending[$];
        int errors = 0;
        int checked = 0;
        int ood_seen = 0;

        task note_input(logic [IN_W-1:0] w);
            elem_t e;
            wigner_elem(w, e);
            pending.push_back(e);
        endtask

        function void check_result(logic [OUT_W-1:0] d, logic u);
            elem_t e;
            if (pending.size() == 0)
            begin
                $error("result item with nothing expected: %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (u) ood_seen++;
            if (d[17:0] !== e.re)
            begin
                $error("value_real expected %0d actual %0d", e.re, $signed(d[17:0]));
                errors++;
            end
            if (d[35:18] !== e.im)
            begin
                $error("value_imag expected %0d actual %0d", e.im, $signed(d[35:18]));
                errors++;
            end
            if (d[OUT_W-1:36] !== '0)
            begin
                $error("m_tdata pad expected 0 actual %h", d[OUT_W-1:36]);
                errors++;
            end
            if (u !== e.ood)
            begin
                $error("out_of_domain expected %0b actual %0b", e.ood, u);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [OUT_W-1:0] m_tdata;
    logic m_tuser;

    // Stall control for the two sides.
    bit no_idle = 0;
    bit hold_off = 0;
    bit stim_done = 0;
    int quiet = 0;
    int sent = 0;

    elem_scoreboard sb = new();

    always #5 clk = ~clk;

    wigner_d_matrix_rank2_top #(.CORDIC_STAGES(STAGES)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // Sample both handshakes at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sb.note_input(s_tdata);
                sent++;
            end
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (stim_done && sb.pending.size() == 0))
                quiet = 0;
            else
                quiet++;
        end
    end

    // Receiver: random stalls, none while no_idle, stalled throughout hold_off.
    always @(negedge clk)
    begin
        if (hold_off)
            m_tready <= 0;
        else
            m_tready <= no_idle || ($urandom_range(99) >= 17);
    end

    always @(posedge clk)
    begin
        if (quiet >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Drive one item; random gap first, then hold until accepted.
    task automatic send_item(input logic [IN_W-1:0] w);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 17)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [IN_W-1:0] pack_in(logic [3:0] l, logic [3:0] k, logic [3:0] m,
                                              logic [15:0] a, logic [15:0] b,
                                              logic [15:0] g);
        return {4'b0, g, b, a, m, k, l};
    endfunction

    // Mostly rank 2 with valid indices; some rank 0 and some junk.
    function automatic logic [IN_W-1:0] rand_item();
        logic [3:0] l, k, m;
        int sel;
        sel = $urandom_range(99);
        if (sel < 75)
        begin
            l = 2;
            k = $urandom_range(4) - 2;
            m = $urandom_range(4) - 2;
        end
        else if (sel < 82)
        begin
            l = 0; k = 0; m = 0;
        end
        else
        begin
            l = $urandom; k = $urandom; m = $urandom;
        end
        return pack_in(l, k, m, $urandom, $urandom, $urandom);
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // Directed: every (k,m) of rank 2 at one set of angles, then extremes, rank 0 and out-of-domain items.
        for (int k = -2; k <= 2; k++)
            for (int m = -2; m <= 2; m += 1)
                send_item(pack_in(4'd2, 4'(k), 4'(m), 16'h0B40, 16'h0780, 16'hF4C0));
        send_item(pack_in(2, 0, 0, 16'h7FFF, 16'h8000, 16'h8000));
        send_item(pack_in(2, 2, -2, 16'h8000, 16'h7FFF, 16'h7FFF));
        send_item(pack_in(2, -2, 2, 16'hFFFF, 16'h1680, 16'h2D00));
        send_item(pack_in(0, 0, 0, 16'h1234, 16'h5678, 16'h9ABC));
        send_item(pack_in(0, 1, 0, 0, 0, 0));
        send_item(pack_in(2, 3, 0, 0, 0, 0));
        send_item(pack_in(2, 0, -8, 0, 0, 0));
        send_item(pack_in(15, 7, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(pack_in(1, 0, 0, 0, 0, 0));
        send_item(pack_in(2, 1, 1, 16'h1680, 16'h1680, 16'h1680));

        // Random: a no-idle stretch, a long receiver hold-off, then mixed.
        for (int i = 0; i < 700; i++)
        begin
            no_idle = (i >= 100 && i < 250);
            if (i == 400)
                fork
                    begin
                        hold_off = 1;
                        repeat (200) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            send_item(rand_item());
        end
        @(negedge clk);
        s_tvalid <= 0;
        no_idle = 0;
        stim_done = 1;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (STAGES + 20) @(posedge clk);

        $display("covered %0d items, %0d results checked, %0d out of domain",
                 sent, sb.checked, sb.ood_seen);
        $display("receiver held off once for 200 cycles; stalls on both sides");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
